// ===== src/pls_pkg.sv =====
package pls_pkg;

   localparam int MAX_PACKETS_DEF = 64;
   localparam int SEQ_W           = 7;
   localparam int STATUS_W        = 3;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW      = 3'd0,
      ST_DUP      = 3'd1,
      ST_COMPLETE = 3'd2,
      ST_MISSING  = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

endpackage

// ===== src/pls_ram.sv =====
module pls_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/packet_loss_scoreboard_core.sv =====
// Receiver loss scoreboard for a numbered transfer.
// req channel: one beat per command. tuser selects the command (0 packet
// arrival, 1 loss check); tdata carries seq_num and total_count.
// rsp channel: status in tuser, missing sequence number in tdata, tlast on
// the final beat of each command.
// An arrival reads its bit of the received map, then decides and writes it
// back. A check that finds nothing to list also passes through the lookup state.
// A check with losses sweeps the map through the memory read port, one entry
// per cycle while no found number waits on a stalled rsp channel, emitting
// each missing number as it is found. Commands are handled one at a time; the
// next command is taken as soon as the previous one is finished, even while
// its result beat still sits in the output register.
// After reset the map memory is cleared one entry at a time, during which
// req_tready stays low. A stalled rsp channel holds the output register and
// freezes the lookup, or the sweep at a missing number, until the beat is taken.
module packet_loss_scoreboard_core #(
   parameter int MAX_PACKETS = pls_pkg::MAX_PACKETS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pls_pkg::REQ_DATA_W-1:0]   req_tdata,  // seq_num[6:0], total_count[13:7]
   input  logic                             req_tuser,  // operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pls_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // missing_seq[6:0]
   output logic [pls_pkg::STATUS_W-1:0]     rsp_tuser,  // status
   output logic                             rsp_tlast
);

   localparam int SW = pls_pkg::SEQ_W;
   localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam logic [SW-1:0] MAXP = SW'(MAX_PACKETS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PACKETS - 1);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_LOOKUP = 4'b0100,
      S_SCAN   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [SW-1:0]       count_ff, count_in;
   logic [SW-1:0]       total_ff, total_in;
   logic [AW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       tot_ff, tot_in;
   logic                fixed_ff, fixed_in;
   pls_pkg::status_type pend_ff, pend_in;
   logic [SW-1:0]       issue_ff, issue_in;
   logic [AW-1:0]       addr_d_ff, addr_d_in;
   logic                dv_ff, dv_in;
   logic [SW-1:0]       remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pls_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SW-1:0]       rsp_seq_ff, rsp_seq_in;
   logic                rsp_last_ff, rsp_last_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [0:0]    wr_data, rd_data;

   logic [SW-1:0] req_seq, req_tot, req_seq_m1;
   logic          req_bad, accept, out_free, missing_hit;

   pls_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PACKETS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_seq    = req_tdata[SW-1:0];
   assign req_tot    = req_tdata[2*SW-1:SW];
   assign req_seq_m1 = req_seq - SW'(1);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign missing_hit = dv_ff && !rd_data[0];

   always_comb begin
      req_bad = (req_seq == '0) || (req_seq > MAXP);
      if (total_ff == '0) begin
         if ((req_tot == '0) || (req_tot > MAXP) || (req_seq > req_tot)) begin
            req_bad = 1'b1;
         end
      end else if (req_seq > total_ff) begin
         req_bad = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      clr_ptr_in    = clr_ptr_ff;
      idx_in        = idx_ff;
      tot_in        = tot_ff;
      fixed_in      = fixed_ff;
      pend_in       = pend_ff;
      issue_in      = issue_ff;
      addr_d_in     = addr_d_ff;
      dv_in         = dv_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ptr_ff;
      wr_data       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = req_seq_m1[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               idx_in = req_seq_m1[AW-1:0];
               tot_in = req_tot;
               if (!req_tuser) begin
                  rd_en    = 1'b1;
                  fixed_in = req_bad;
                  pend_in  = pls_pkg::ST_RANGE;
                  state_in = S_LOOKUP;
               end else if ((count_ff == '0) || (count_ff >= total_ff)) begin
                  fixed_in = 1'b1;
                  pend_in  = (count_ff == '0) ? pls_pkg::ST_EMPTY : pls_pkg::ST_COMPLETE;
                  state_in = S_LOOKUP;
               end else begin
                  issue_in  = '0;
                  dv_in     = 1'b0;
                  remain_in = total_ff - count_ff;
                  state_in  = S_SCAN;
               end
            end
         end
         S_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_seq_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (fixed_ff) begin
                  rsp_status_in = pend_ff;
               end else if (rd_data[0]) begin
                  rsp_status_in = pls_pkg::ST_DUP;
               end else begin
                  rsp_status_in = pls_pkg::ST_NEW;
                  wr_en         = 1'b1;
                  wr_addr       = idx_ff;
                  wr_data       = 1'b1;
                  count_in      = count_ff + SW'(1);
                  if (total_ff == '0) begin
                     total_in = tot_ff;
                  end
               end
            end
         end
         S_SCAN: begin
            rd_addr = issue_ff[AW-1:0];
            if (!missing_hit || out_free) begin
               if (missing_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pls_pkg::ST_MISSING;
                  rsp_seq_in    = SW'(addr_d_ff) + SW'(1);
                  rsp_last_in   = (remain_ff == SW'(1));
                  remain_in     = remain_ff - SW'(1);
               end
               if (missing_hit && (remain_ff == SW'(1))) begin
                  dv_in    = 1'b0;
                  state_in = S_IDLE;
               end else if (issue_ff < total_ff) begin
                  rd_en     = 1'b1;
                  addr_d_in = issue_ff[AW-1:0];
                  issue_in  = issue_ff + SW'(1);
                  dv_in     = 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         total_ff     <= '0;
         clr_ptr_ff   <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         clr_ptr_ff   <= clr_ptr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      tot_ff        <= tot_in;
      fixed_ff      <= fixed_in;
      pend_ff       <= pend_in;
      issue_ff      <= issue_in;
      addr_d_ff     <= addr_d_in;
      remain_ff     <= remain_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pls_pkg::RSP_DATA_W'(rsp_seq_ff);
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_le_total: assert property (@(posedge clock) disable iff (reset)
      count_ff <= total_ff)
      else $error("received count exceeds expected total");

   a_missing_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == pls_pkg::ST_MISSING) |->
         (rsp_seq_ff != '0) && (rsp_seq_ff <= total_ff))
      else $error("missing number out of range");

   a_single_beat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != pls_pkg::ST_MISSING) |->
         rsp_last_ff && (rsp_seq_ff == '0))
      else $error("single-beat result malformed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("command taken while another is in progress");

endmodule

// ===== tb/sv/packet_loss_scoreboard_core_test.sv =====
module packet_loss_scoreboard_core_test;

   localparam int PKT_LIMIT    = pls_pkg::MAX_PACKETS_DEF;
   localparam int SEQ_W        = pls_pkg::SEQ_W;
   localparam int STATUS_W     = pls_pkg::STATUS_W;
   localparam int REQ_DATA_W   = pls_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = pls_pkg::RSP_DATA_W;
   localparam bit OP_ARRIVAL   = 1'b0;
   localparam bit OP_CHECK     = 1'b1;
   localparam int RANDOM_ITEMS = 480;
   localparam int HOLD_CYCLES  = 200;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      pls_pkg::status_type status;
      logic [SEQ_W-1:0]    missing_seq;
      logic                last;
   } loss_beat_type;

   // mirrors the received map and produces the beats each command should cause
   class loss_tracker_type;
      bit [PKT_LIMIT-1:0] rx_map;
      bit [SEQ_W-1:0]     rx_count;
      bit [SEQ_W-1:0]     xfer_total;
      loss_beat_type      pending_beats[$];
      int                 errors;
      int                 beats_ok;
      int                 arrivals;
      int                 checks;
      int                 status_hits[6];

      function int outstanding();
         return pending_beats.size();
      endfunction

      function void push(pls_pkg::status_type st, bit [SEQ_W-1:0] miss, bit lst);
         loss_beat_type b;
         b.status      = st;
         b.missing_seq = miss;
         b.last        = lst;
         pending_beats.push_back(b);
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
      endfunction

      function void note_command(bit op, bit [SEQ_W-1:0] seq, bit [SEQ_W-1:0] tot);
         int lim;
         int listed;
         if (op == OP_ARRIVAL) begin
            arrivals++;
            if (seq == 0 || seq > PKT_LIMIT ||
                (xfer_total == 0 && (tot == 0 || tot > PKT_LIMIT || seq > tot)) ||
                (xfer_total != 0 && seq > xfer_total)) begin
               push(pls_pkg::ST_RANGE, '0, 1'b1);
            end else if (rx_map[seq-1]) begin
               push(pls_pkg::ST_DUP, '0, 1'b1);
            end else begin
               if (xfer_total == 0) begin
                  xfer_total = tot;
               end
               rx_map[seq-1] = 1'b1;
               rx_count++;
               push(pls_pkg::ST_NEW, '0, 1'b1);
            end
         end else begin
            checks++;
            if (rx_count == 0) begin
               push(pls_pkg::ST_EMPTY, '0, 1'b1);
            end else if (rx_count >= xfer_total) begin
               push(pls_pkg::ST_COMPLETE, '0, 1'b1);
            end else begin
               lim    = (xfer_total > PKT_LIMIT) ? PKT_LIMIT : xfer_total;
               listed = 0;
               for (int n = 1; n <= lim; n++) begin
                  if (!rx_map[n-1]) begin
                     push(pls_pkg::ST_MISSING, SEQ_W'(n), 1'b0);
                     listed++;
                  end
               end
               if (listed == 0) begin
                  push(pls_pkg::ST_COMPLETE, '0, 1'b1);
               end else begin
                  pending_beats[pending_beats.size()-1].last = 1'b1;
               end
            end
         end
      endfunction

      function void check_beat(logic [STATUS_W-1:0] st, logic [RSP_DATA_W-1:0] data,
                               logic lst);
         loss_beat_type want;
         if (pending_beats.size() == 0) begin
            flag($sformatf("unexpected beat status %0d data %0d last %0b", st, data, lst));
            return;
         end
         want = pending_beats.pop_front();
         if (st !== want.status || data !== RSP_DATA_W'(want.missing_seq) ||
             lst !== want.last) begin
            flag($sformatf("exp status %0d seq %0d last %0b, got status %0d seq %0d last %0b",
                           want.status, want.missing_seq, want.last, st, data, lst));
         end else begin
            beats_ok++;
            status_hits[want.status]++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   loss_tracker_type board = new();
   bit               steady_feed = 1'b0;
   bit               hold_go     = 1'b0;

   always #5 clock = ~clock;

   packet_loss_scoreboard_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_beat(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_command(input bit op, input bit [SEQ_W-1:0] seq,
                               input bit [SEQ_W-1:0] tot);
      while (!steady_feed && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({tot, seq});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_command(op, seq, tot);
   endtask

   // drain everything before going on; valid is dropped while draining
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      int cyc;
      int hold_left;
      cyc       = 0;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (cyc >= 2000 && cyc < 3000) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 18);
         end
         @(posedge clock);
         cyc++;
      end
   end

   initial begin : req_side
      int xfer_len;
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      xfer_len = $urandom_range(64, 40);

      // empty map, then every way an arrival can be out of range before the total is fixed
      send_command(OP_CHECK, 0, 0);
      send_command(OP_ARRIVAL, 0, 10);
      send_command(OP_ARRIVAL, 65, 64);
      send_command(OP_ARRIVAL, 127, 127);
      send_command(OP_ARRIVAL, 5, 0);
      send_command(OP_ARRIVAL, 3, 65);
      send_command(OP_ARRIVAL, 9, 8);
      send_command(OP_CHECK, 127, 127);
      // first good packet fixes the total; later totals are ignored
      send_command(OP_ARRIVAL, 1, SEQ_W'(xfer_len));
      send_command(OP_ARRIVAL, 1, 5);
      send_command(OP_ARRIVAL, SEQ_W'(xfer_len), 0);
      send_command(OP_ARRIVAL, SEQ_W'(xfer_len + 1), 64);
      send_command(OP_ARRIVAL, 64, 127);
      send_command(OP_CHECK, 0, 0);
      send_command(OP_ARRIVAL, 0, 0);
      send_command(OP_CHECK, 85, 42);
      send_command(OP_ARRIVAL, 2, SEQ_W'(xfer_len));
      send_command(OP_CHECK, 127, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady_feed = (i >= 150 && i < 250);
         if (i == 60) begin
            hold_go = 1'b1;
         end
         if (i == 320) begin
            pause_until_drained();
         end
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_command(OP_CHECK, SEQ_W'($urandom_range(127)), SEQ_W'($urandom_range(127)));
         end else if (pick < 85) begin
            send_command(OP_ARRIVAL, SEQ_W'($urandom_range(xfer_len, 1)),
                         SEQ_W'($urandom_range(127)));
         end else begin
            send_command(OP_ARRIVAL, SEQ_W'($urandom_range(127)),
                         SEQ_W'($urandom_range(127)));
         end
      end
      req_tvalid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("ran %0d arrivals and %0d loss checks against a %0d-packet transfer",
               board.arrivals, board.checks, xfer_len);
      $display("%0d beats matched: new %0d dup %0d complete %0d missing %0d empty %0d range %0d",
               board.beats_ok, board.status_hits[pls_pkg::ST_NEW],
               board.status_hits[pls_pkg::ST_DUP], board.status_hits[pls_pkg::ST_COMPLETE],
               board.status_hits[pls_pkg::ST_MISSING], board.status_hits[pls_pkg::ST_EMPTY],
               board.status_hits[pls_pkg::ST_RANGE]);
      if (board.errors == 0) begin
         $display("[packet_loss_scoreboard_core] OK");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("[packet_loss_scoreboard_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("timeout with %0d beats outstanding", board.outstanding());
      $display("[packet_loss_scoreboard_core] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
src/pls_pkg.sv
src/pls_ram.sv
src/packet_loss_scoreboard_core.sv
tb/sv/packet_loss_scoreboard_core_test.sv
